>>> rtl/core/pwed_pkg.sv
// pwed_pkg: shared types and constants of the pairwise euclidean distance core
// no dependencies; used by pwed_isqrt and pairwise_euclidean_distance_core

package pwed_pkg;

    localparam int ID_W    = 8;   // width of a point id on the ports
    localparam int COORD_W = 16;  // width of a coordinate on the ports
    localparam int DIST_W  = 17;  // width of the reported distance

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_QUERY = 1'b1
    } req_type_t;

    // ids of a query, carried alongside the arithmetic
    typedef struct packed {
        logic [ID_W-1:0] row_id;
        logic [ID_W-1:0] col_id;
        logic            same_id;
    } pair_tag_t;

endpackage

>>> rtl/core/pwed_isqrt.sv
// pwed_isqrt: pipelined integer square root, one root bit per stage
// depends on pwed_pkg (pair_tag_t); elastic stages with valid/ready

module pwed_isqrt #(
    parameter int RT_W = 17
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2*RT_W-1:0]        in_rad,
    input  pwed_pkg::pair_tag_t      in_tag,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [RT_W-1:0]          out_root,
    output pwed_pkg::pair_tag_t      out_tag
);

    localparam int RAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 2;

    logic                valid_reg [RT_W];
    logic                rdy       [RT_W];
    logic [RT_W-1:0]     root_reg  [RT_W];
    pwed_pkg::pair_tag_t tag_reg   [RT_W];
    // remainder and radicand are not needed past the last step
    logic [REM_W-1:0]    rem_reg   [RT_W-1];
    logic [RAD_W-1:0]    rad_reg   [RT_W-1];

    for (genvar k = 0; k < RT_W; k++) begin : g_step
        logic                cur_valid;
        logic [REM_W-1:0]    cur_rem;
        logic [RT_W-1:0]     cur_root;
        logic [RAD_W-1:0]    cur_rad;
        pwed_pkg::pair_tag_t cur_tag;
        logic [REM_W-1:0]    rem_sh;
        logic [REM_W-1:0]    trial;
        logic                fits;

        if (k == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem   = '0;
            assign cur_root  = '0;
            assign cur_rad   = in_rad;
            assign cur_tag   = in_tag;
        end else begin : g_next
            assign cur_valid = valid_reg[k-1];
            assign cur_rem   = rem_reg[k-1];
            assign cur_root  = root_reg[k-1];
            assign cur_rad   = rad_reg[k-1];
            assign cur_tag   = tag_reg[k-1];
        end

        if (k == RT_W - 1) begin : g_rdy_last
            assign rdy[k] = !valid_reg[k] || out_ready;
        end else begin : g_rdy_mid
            assign rdy[k] = !valid_reg[k] || rdy[k+1];
        end

        // bring down the next two radicand bits and try (4*root + 1)
        assign rem_sh = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1 -: 2]};
        assign trial  = {cur_root, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k] && cur_valid) begin
                root_reg[k] <= {cur_root[RT_W-2:0], fits};
                tag_reg[k]  <= cur_tag;
            end
        end

        if (k < RT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (rdy[k] && cur_valid) begin
                    rem_reg[k] <= fits ? (rem_sh - trial) : rem_sh;
                    rad_reg[k] <= {cur_rad[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[RT_W-1];
    assign out_root  = root_reg[RT_W-1];
    assign out_tag   = tag_reg[RT_W-1];

endmodule

>>> rtl/core/pairwise_euclidean_distance_core.sv
// pairwise_euclidean_distance_core: point table plus truncated distance pipeline
// depends on pwed_pkg and pwed_isqrt
//
//  channel | direction | beat carries                               | results
//  s_      | in        | req_type, first_id, second_id, x/y_coord   | store: none, query: one
//  m_      | out       | row_id, col_id, distance                   | one per query, in order
//
// one beat per cycle while s_ready is high; a query passes table read, difference, squares,
// sum, then one root bit per stage before m_valid rises
// a store writes the table in the cycle it is accepted and leaves no trace in the pipeline
// every stage holds its own valid bit and fills bubbles, so the input keeps moving while
// a finished result waits on m_ready; only a fully occupied pipeline drops s_ready
// reset clears the valid bits only; the point table is undefined until written

module pairwise_euclidean_distance_core #(
    parameter int MAX_POINTS = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [pwed_pkg::ID_W-1:0]    s_first_id,
    input  logic [pwed_pkg::ID_W-1:0]    s_second_id,
    input  logic [pwed_pkg::COORD_W-1:0] s_x_coord,
    input  logic [pwed_pkg::COORD_W-1:0] s_y_coord,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pwed_pkg::ID_W-1:0]    m_row_id,
    output logic [pwed_pkg::ID_W-1:0]    m_col_id,
    output logic [pwed_pkg::DIST_W-1:0]  m_distance
);

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int ID_VALS = 2 ** pwed_pkg::ID_W;
    localparam int PT_W    = 2 * COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int RT_W    = COORD_BITS + 1;
    localparam int RAD_W   = 2 * RT_W;

    // id to table slot, wrapping modulo the table depth
    logic [ADDR_W-1:0] slot_lut [ID_VALS];
    for (genvar g = 0; g < ID_VALS; g++) begin : g_slot
        assign slot_lut[g] = ADDR_W'(g % MAX_POINTS);
    end

    logic [PT_W-1:0] point_mem [MAX_POINTS];

    logic              st_acc;
    logic              q_acc;
    logic [ADDR_W-1:0] wr_addr;
    logic [PT_W-1:0]   wr_data;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;

    // stage 0: table read data
    logic                st0_v_reg;
    logic [PT_W-1:0]     pa_reg;
    logic [PT_W-1:0]     pb_reg;
    pwed_pkg::pair_tag_t st0_tag_reg;
    // stage 1: absolute differences
    logic                  st1_v_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    pwed_pkg::pair_tag_t   st1_tag_reg;
    // stage 2: squares
    logic                st2_v_reg;
    logic [SQ_W-1:0]     sqx_reg;
    logic [SQ_W-1:0]     sqy_reg;
    pwed_pkg::pair_tag_t st2_tag_reg;
    // stage 3: sum of squares
    logic                st3_v_reg;
    logic [RAD_W-1:0]    sum_reg;
    pwed_pkg::pair_tag_t st3_tag_reg;

    logic rdy0, rdy1, rdy2, rdy3;
    logic iq_in_ready;

    logic [COORD_BITS-1:0] ax, ay, bx, by;
    logic [RT_W-1:0]       root;
    pwed_pkg::pair_tag_t   out_tag;

    assign rdy3    = !st3_v_reg || iq_in_ready;
    assign rdy2    = !st2_v_reg || rdy3;
    assign rdy1    = !st1_v_reg || rdy2;
    assign rdy0    = !st0_v_reg || rdy1;
    assign s_ready = rdy0;

    assign st_acc = s_valid && s_ready && (s_req_type == pwed_pkg::REQ_STORE);
    assign q_acc  = s_valid && s_ready && (s_req_type == pwed_pkg::REQ_QUERY);

    assign wr_addr   = slot_lut[s_first_id];
    assign rd_addr_a = slot_lut[s_first_id];
    assign rd_addr_b = slot_lut[s_second_id];
    assign wr_data   = {COORD_BITS'(s_y_coord), COORD_BITS'(s_x_coord)};

    // one write port, two read ports with registered data
    always_ff @(posedge aclk) begin
        if (st_acc) begin
            point_mem[wr_addr] <= wr_data;
        end
        if (q_acc) begin
            pa_reg <= point_mem[rd_addr_a];
            pb_reg <= point_mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_acc) begin
            st0_tag_reg.row_id  <= s_first_id;
            st0_tag_reg.col_id  <= s_second_id;
            st0_tag_reg.same_id <= (s_first_id == s_second_id);
        end
    end

    assign ax = pa_reg[COORD_BITS-1:0];
    assign ay = pa_reg[PT_W-1:COORD_BITS];
    assign bx = pb_reg[COORD_BITS-1:0];
    assign by = pb_reg[PT_W-1:COORD_BITS];

    always_ff @(posedge aclk) begin
        if (rdy1 && st0_v_reg) begin
            dx_reg      <= (ax >= bx) ? (ax - bx) : (bx - ax);
            dy_reg      <= (ay >= by) ? (ay - by) : (by - ay);
            st1_tag_reg <= st0_tag_reg;
        end
        if (rdy2 && st1_v_reg) begin
            sqx_reg     <= dx_reg * dx_reg;
            sqy_reg     <= dy_reg * dy_reg;
            st2_tag_reg <= st1_tag_reg;
        end
        if (rdy3 && st2_v_reg) begin
            sum_reg     <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
            st3_tag_reg <= st2_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_v_reg <= 1'b0;
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
        end else begin
            if (rdy0) st0_v_reg <= q_acc;
            if (rdy1) st1_v_reg <= st0_v_reg;
            if (rdy2) st2_v_reg <= st1_v_reg;
            if (rdy3) st3_v_reg <= st2_v_reg;
        end
    end

    pwed_isqrt #(
        .RT_W (RT_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st3_v_reg),
        .in_ready  (iq_in_ready),
        .in_rad    (sum_reg),
        .in_tag    (st3_tag_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_root  (root),
        .out_tag   (out_tag)
    );

    assign m_row_id   = out_tag.row_id;
    assign m_col_id   = out_tag.col_id;
    // same id answers zero without regard to the table contents
    assign m_distance = out_tag.same_id ? '0 : pwed_pkg::DIST_W'(root);

    a_store_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        st_acc |=> point_mem[$past(wr_addr)] == $past(wr_data))
        else $error("stored point not found in table");

    a_same_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_row_id == m_col_id) |-> m_distance == '0)
        else $error("same id pair with nonzero distance");

    a_query_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        q_acc |=> st0_v_reg)
        else $error("accepted query missing from first stage");

    a_store_no_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        st_acc |=> !st0_v_reg)
        else $error("store beat entered the distance pipeline");

endmodule
